[src/mhit_pkg.sv]
// shared types, constants and codes of the multilevel hash id table
package mhit_pkg;

	localparam int LEVELS      = 5;
	localparam int SLOTS       = 128;
	localparam int LVL_W       = 3;
	localparam int SLOT_W      = 7;
	localparam int ADDR_W      = LVL_W + SLOT_W;
	localparam int DEPTH       = LEVELS * SLOTS;
	localparam int KEY_W       = 31;
	localparam int MOD_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int TRIES_W     = 10;
	localparam logic [TRIES_W-1:0] TRIES_MAX = 10'd641;

	// remainder unit: dividend padded to 32 bits, four bits a cycle
	localparam int MOD_BITS   = 32;
	localparam int MOD_STEP   = 4;
	localparam int MOD_PASSES = MOD_BITS / MOD_STEP;
	localparam int MOD_CNT_W  = 3;

	localparam logic [FUNC_W-1:0] FN_FIND  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_BAD   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd6;

	typedef logic [LEVELS-1:0][MOD_W-1:0]  mod_vec_t;
	typedef logic [LEVELS-1:0][SLOT_W-1:0] rem_vec_t;

	localparam mod_vec_t MOD_RESET = {8'd73, 8'd79, 8'd83, 8'd89, 8'd97};

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    ident;
		logic [LVL_W-1:0]    level_hit;
		logic [SLOT_W-1:0]   slot_index;
	} out_item_t;

	typedef struct packed {
		logic                idle;
		logic                load;
		logic                clr_step;
		logic                next_id;
		logic                mod_start;
		logic                rd_issue;
		logic [LVL_W-1:0]    lvl;
		logic                note_empty;
		logic                wr_key;
		logic                wr_zero;
		logic                wr_empty;
		logic                res_load;
		logic [STATUS_W-1:0] res_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic              mod_done;
		logic [FUNC_W-1:0] func;
		logic              key_zero;
		logic              slot_empty;
		logic              slot_match;
		logic              have_empty;
		logic              out_busy;
	} dp_status_t;

endpackage

[src/mhit_modunit.sv]
// five-lane remainder unit, key mod modulus of every level, four bits a cycle
module mhit_modunit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mhit_pkg::KEY_W-1:0]    key,
	input  mhit_pkg::mod_vec_t            mods,
	output mhit_pkg::rem_vec_t            rem,
	output logic                          done
);

	logic [mhit_pkg::MOD_BITS-1:0]  div_q;
	logic [mhit_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	mhit_pkg::rem_vec_t             rem_q;
	mhit_pkg::rem_vec_t             rem_nx;

	always_comb begin
		logic [mhit_pkg::SLOT_W-1:0] r;
		logic [mhit_pkg::MOD_W-1:0]  t;
		rem_nx = rem_q;
		for (int l = 0; l < mhit_pkg::LEVELS; l++) begin
			r = rem_q[l];
			for (int s = 0; s < mhit_pkg::MOD_STEP; s++) begin
				t = {r, div_q[mhit_pkg::MOD_BITS-1-s]};
				if (t >= mods[l]) begin
					t = t - mods[l];
				end
				r = t[mhit_pkg::SLOT_W-1:0];
			end
			rem_nx[l] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == mhit_pkg::MOD_CNT_W'(mhit_pkg::MOD_PASSES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= {1'b0, key};
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << mhit_pkg::MOD_STEP;
			rem_q <= rem_nx;
		end
	end

	assign rem  = rem_q;
	assign done = !busy_q;

endmodule

[src/mhit_datapath.sv]
// datapath: modulus registers, slot memory, id counter, probe and result registers
module mhit_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mhit_pkg::ctrl_cmd_t               cmd,
	output mhit_pkg::dp_status_t              st,
	input  mhit_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mhit_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [mhit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mhit_pkg::MOD_W-1:0]        cfg_data
);

	logic [mhit_pkg::KEY_W-1:0]  mem [mhit_pkg::DEPTH];
	mhit_pkg::mod_vec_t          mod_q;
	mhit_pkg::mod_vec_t          mod_eff;
	mhit_pkg::rem_vec_t          rem;
	logic                        mod_done;
	logic [mhit_pkg::FUNC_W-1:0] func_q;
	logic [mhit_pkg::KEY_W-1:0]  key_q;
	logic [mhit_pkg::KEY_W-1:0]  ident_q;
	logic [mhit_pkg::KEY_W-1:0]  ident_nx;
	logic [mhit_pkg::KEY_W-1:0]  rd_q;
	logic [mhit_pkg::ADDR_W-1:0] clr_q;
	logic [mhit_pkg::ADDR_W-1:0] cur_addr;
	logic [mhit_pkg::ADDR_W-1:0] emp_addr;
	logic [mhit_pkg::LVL_W-1:0]  emp_lvl_q;
	logic [mhit_pkg::SLOT_W-1:0] emp_pos_q;
	logic                        have_empty_q;
	logic                        out_valid_q;
	mhit_pkg::out_item_t         out_q;
	logic                        we;
	logic [mhit_pkg::ADDR_W-1:0] wa;
	logic [mhit_pkg::KEY_W-1:0]  wd;

	// out of range moduli: zero acts as one, above the slot count acts as the slot count
	always_comb begin
		for (int l = 0; l < mhit_pkg::LEVELS; l++) begin
			if (mod_q[l] == '0) begin
				mod_eff[l] = mhit_pkg::MOD_W'(1);
			end else if (mod_q[l] > mhit_pkg::MOD_W'(mhit_pkg::SLOTS)) begin
				mod_eff[l] = mhit_pkg::MOD_W'(mhit_pkg::SLOTS);
			end else begin
				mod_eff[l] = mod_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= mhit_pkg::MOD_RESET;
		end else if (cfg_we && cfg_index < mhit_pkg::CFG_IDX_W'(mhit_pkg::LEVELS)) begin
			mod_q[cfg_index] <= cfg_data;
		end
	end

	mhit_modunit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mod_start),
		.key    (key_q),
		.mods   (mod_eff),
		.rem    (rem),
		.done   (mod_done)
	);

	assign ident_nx = (ident_q == '1) ? mhit_pkg::KEY_W'(1) : ident_q + 1'b1;
	assign cur_addr = {cmd.lvl, rem[cmd.lvl]};
	assign emp_addr = {emp_lvl_q, emp_pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q      <= mhit_pkg::KEY_W'(1);
			clr_q        <= '0;
			have_empty_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.next_id) begin
				ident_q <= ident_nx;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load) begin
				have_empty_q <= 1'b0;
			end else if (cmd.note_empty) begin
				have_empty_q <= 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_data.func;
			key_q  <= in_data.key;
		end else if (cmd.next_id) begin
			key_q <= ident_nx;
		end
		if (cmd.note_empty) begin
			emp_lvl_q <= cmd.lvl;
			emp_pos_q <= rem[cmd.lvl];
		end
	end

	// single write port: clearing pass, claim, release, deferred insert
	always_comb begin
		we = 1'b1;
		wa = cur_addr;
		wd = key_q;
		if (cmd.clr_step) begin
			wa = clr_q;
			wd = '0;
		end else if (cmd.wr_zero) begin
			wd = '0;
		end else if (cmd.wr_empty) begin
			wa = emp_addr;
		end else if (!cmd.wr_key) begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rd_q <= mem[cur_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status <= cmd.res_code;
			case (cmd.res_code)
				mhit_pkg::ST_FOUND, mhit_pkg::ST_ALLOCATED, mhit_pkg::ST_FREED: begin
					out_q.ident      <= key_q;
					out_q.level_hit  <= cmd.lvl;
					out_q.slot_index <= rem[cmd.lvl];
				end
				mhit_pkg::ST_INSERTED: begin
					out_q.ident      <= key_q;
					out_q.level_hit  <= emp_lvl_q;
					out_q.slot_index <= emp_pos_q;
				end
				default: begin
					out_q.ident      <= '0;
					out_q.level_hit  <= '0;
					out_q.slot_index <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign st.clr_last   = (clr_q == mhit_pkg::ADDR_W'(mhit_pkg::DEPTH - 1));
	assign st.mod_done   = mod_done;
	assign st.func       = func_q;
	assign st.key_zero   = (key_q == '0);
	assign st.slot_empty = (rd_q == '0);
	assign st.slot_match = (rd_q == key_q);
	assign st.have_empty = have_empty_q;
	assign st.out_busy   = out_valid_q && out_stall;

endmodule

[src/mhit_ctrl.sv]
// controller state machine: clearing pass, level probing, retries, result hand-off
module mhit_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  mhit_pkg::dp_status_t  st,
	output mhit_pkg::ctrl_cmd_t   cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_START  = 4'd2;
	localparam logic [3:0] S_MSTART = 4'd3;
	localparam logic [3:0] S_MWAIT  = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_EV     = 4'd6;
	localparam logic [3:0] S_INS    = 4'd7;
	localparam logic [3:0] S_FINISH = 4'd8;

	logic [3:0]                    state_q, state_nx;
	logic [mhit_pkg::LVL_W-1:0]    lvl_q, lvl_nx;
	logic [mhit_pkg::TRIES_W-1:0]  tries_q, tries_nx;
	logic [mhit_pkg::STATUS_W-1:0] code_q, code_nx;
	logic                          last_lvl;

	assign last_lvl = (lvl_q == mhit_pkg::LVL_W'(mhit_pkg::LEVELS - 1));

	always_comb begin
		state_nx = state_q;
		lvl_nx   = lvl_q;
		tries_nx = tries_q;
		code_nx  = code_q;
		cmd      = '0;
		cmd.lvl  = lvl_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.idle = 1'b1;
				cmd.load = in_valid;
				if (in_valid) begin
					state_nx = S_START;
				end
			end
			S_START: begin
				lvl_nx   = '0;
				tries_nx = '0;
				if (st.func == mhit_pkg::FN_ALLOC) begin
					cmd.next_id = 1'b1;
					state_nx    = S_MSTART;
				end else if (st.func == mhit_pkg::FN_BAD || st.key_zero) begin
					code_nx  = mhit_pkg::ST_INVALID;
					state_nx = S_FINISH;
				end else begin
					state_nx = S_MSTART;
				end
			end
			S_MSTART: begin
				cmd.mod_start = 1'b1;
				lvl_nx        = '0;
				state_nx      = S_MWAIT;
			end
			S_MWAIT: begin
				if (st.mod_done) begin
					state_nx = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_nx     = S_EV;
			end
			S_EV: begin
				state_nx = S_FINISH;
				case (st.func)
					mhit_pkg::FN_FIND: begin
						if (!st.slot_empty && st.slot_match) begin
							code_nx = mhit_pkg::ST_FOUND;
						end else begin
							cmd.note_empty = st.slot_empty && !st.have_empty;
							state_nx       = last_lvl ? S_INS : S_RD;
							lvl_nx         = last_lvl ? lvl_q : lvl_q + 1'b1;
						end
					end
					mhit_pkg::FN_ALLOC: begin
						if (st.slot_empty) begin
							cmd.wr_key = 1'b1;
							code_nx    = mhit_pkg::ST_ALLOCATED;
						end else if (st.slot_match) begin
							if (tries_q == mhit_pkg::TRIES_MAX) begin
								code_nx = mhit_pkg::ST_FULL;
							end else begin
								cmd.next_id = 1'b1;
								tries_nx    = tries_q + 1'b1;
								state_nx    = S_MSTART;
							end
						end else if (last_lvl) begin
							code_nx = mhit_pkg::ST_FULL;
						end else begin
							lvl_nx   = lvl_q + 1'b1;
							state_nx = S_RD;
						end
					end
					default: begin
						if (st.slot_match) begin
							cmd.wr_zero = 1'b1;
							code_nx     = mhit_pkg::ST_FREED;
						end else if (last_lvl) begin
							code_nx = mhit_pkg::ST_ABSENT;
						end else begin
							lvl_nx   = lvl_q + 1'b1;
							state_nx = S_RD;
						end
					end
				endcase
			end
			S_INS: begin
				if (st.have_empty) begin
					cmd.wr_empty = 1'b1;
					code_nx      = mhit_pkg::ST_INSERTED;
				end else begin
					code_nx = mhit_pkg::ST_FULL;
				end
				state_nx = S_FINISH;
			end
			S_FINISH: begin
				cmd.res_code = code_q;
				if (!st.out_busy) begin
					cmd.res_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lvl_q   <= '0;
			tries_q <= '0;
			code_q  <= mhit_pkg::ST_FOUND;
		end else begin
			state_q <= state_nx;
			lvl_q   <= lvl_nx;
			tries_q <= tries_nx;
			code_q  <= code_nx;
		end
	end

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !(cmd.wr_key || cmd.wr_zero || cmd.wr_empty))
		else $error("slot write while idle");
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= mhit_pkg::LVL_W'(mhit_pkg::LEVELS - 1))
		else $error("level counter out of range");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !st.out_busy)
		else $error("result loaded over a held result");
	a_tries_range: assert property (@(posedge clk) disable iff (!arst_n)
		tries_q <= mhit_pkg::TRIES_MAX)
		else $error("retry counter out of range");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_START)
		else $error("accepted transfer did not start");

endmodule

[src/multilevel_hash_id_table.sv]
// top level of the multilevel hash id table
//
//  channel | signals                          | moves
//  in      | in_valid, in_stall, in_data      | func, key
//  out     | out_valid, out_stall, out_data   | status, ident, level_hit, slot_index
//  cfg     | cfg_we, cfg_index, cfg_data      | modulus of levels 0..4
//
// an item: the idle state takes it, then decode, remainder unit start, a wait on it (passes
// of 4 bits on the 32-bit dividend), slot read and compare per level probed, an insert after
// a full find pass and the hand-off; an invalid request skips to the hand-off after decode
// after reset a clearing pass writes all 640 slots, one a cycle, with in_stall high
// in_stall is low only between items; a finished result waits in the output register
// and a stalled out side holds the next result at its last cycle until the transfer
module multilevel_hash_id_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mhit_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mhit_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [mhit_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mhit_pkg::MOD_W-1:0]        cfg_data
);

	// command and status between controller and datapath
	mhit_pkg::ctrl_cmd_t  cmd;
	mhit_pkg::dp_status_t st;

	// controller: clearing pass, probe sequencing, allocate retries
	mhit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: moduli, remainder unit, slot memory, output register
	mhit_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// an input transfer is taken only while the controller sits idle
	assign in_stall = !cmd.idle;

endmodule
